// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the framer RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define FRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define FRM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FRM_ASSERT(lbl, prop, msg)
`define FRM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/frm_pkg.sv =====
// Types and constants of the hex ASCII configuration framer.
// No dependencies; used by all framer modules and the top level.
package frm_pkg;

  localparam logic [7:0] CHR_STX  = 8'h02;
  localparam logic [7:0] CHR_ETX  = 8'h03;
  localparam logic [7:0] CHR_ZERO = 8'd48;
  localparam logic [7:0] CHR_ONE  = 8'd49;
  localparam logic [7:0] HEX_OFS_DIGIT  = 8'd48;
  localparam logic [7:0] HEX_OFS_LETTER = 8'd55;

  localparam logic [15:0] DUMMIES_PRIMARY = 16'd6;
  localparam logic [15:0] DUMMIES_UPDATE  = 16'd1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  typedef struct packed {
    logic        kind;     // CMD_HEADER or CMD_DATA
    logic        primary;  // header: primary configuration
    logic        trailer;  // append "00" and the ETX run after this item
    logic [15:0] len;      // header: length field
    logic [7:0]  data;     // data: byte to encode
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = {4'b0, nib} + ((nib < 4'd10) ? HEX_OFS_DIGIT : HEX_OFS_LETTER);
  endfunction

endpackage

// ===== hdl/frm_channels.sv =====
// Valid/ready channel interfaces of the framer: item input and character output.
// Depends on nothing but plain logic types.
interface frm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        primary_mode;
  logic [14:0] frame_size;
  logic [7:0]  data_byte;

  modport source (output valid, action, primary_mode, frame_size, data_byte, input ready);
  modport sink   (input valid, action, primary_mode, frame_size, data_byte, output ready);
endinterface

interface frm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

// ===== hdl/frm_front.sv =====
// Front end of the framer: accepts items, tracks the open frame, issues commands.
// Depends on frm_pkg and frm_in_if.
`include "assert_macros.svh"
module frm_front import frm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  frm_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic        frame_open_r, frame_open_nxt;
  logic [14:0] bytes_left_r, bytes_left_nxt;
  logic        accept;
  logic [15:0] sum;
  logic [14:0] left_dec;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sum         = {1'b0, in_ch.frame_size} +
                       (in_ch.primary_mode ? DUMMIES_PRIMARY : DUMMIES_UPDATE);
  assign left_dec    = bytes_left_r - 15'd1;

  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    q_push         = 1'b0;
    q_cmd.kind     = CMD_HEADER;
    q_cmd.primary  = in_ch.primary_mode;
    q_cmd.trailer  = 1'b0;
    q_cmd.len      = {sum[14:0], 1'b0};
    q_cmd.data     = in_ch.data_byte;
    if (accept) begin
      if (in_ch.action == ACT_START) begin
        // abandon any open frame
        q_push         = 1'b1;
        q_cmd.trailer  = (in_ch.frame_size == 15'd0);
        frame_open_nxt = (in_ch.frame_size != 15'd0);
        bytes_left_nxt = in_ch.frame_size;
      end else if (frame_open_r) begin
        q_push         = 1'b1;
        q_cmd.kind     = CMD_DATA;
        q_cmd.trailer  = (left_dec == 15'd0);
        frame_open_nxt = (left_dec != 15'd0);
        bytes_left_nxt = left_dec;
      end
      // drop data with no open frame
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= 15'd0;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  `FRM_ASSERT(a_open_matches_count, frame_open_r == (bytes_left_r != 15'd0), "frame state out of step")
  `FRM_ASSERT_NEVER(a_push_when_full, q_push && q_full, "command pushed into full queue")

endmodule

// ===== hdl/frm_queue.sv =====
// Short command queue between the framer front and back ends.
// Depends on frm_pkg for the command type.
`include "assert_macros.svh"
module frm_queue import frm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `FRM_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `FRM_ASSERT_NEVER(a_pop_empty, pop && !head_valid, "pop from empty queue")

endmodule

// ===== hdl/frm_back.sv =====
// Back end of the framer: expands commands into characters through an output register.
// Depends on frm_pkg and frm_out_if.
`include "assert_macros.svh"
module frm_back import frm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  frm_out_if.source  out_ch
);

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_BYTE = 2'd2;
  localparam logic [1:0] PH_TRL  = 2'd3;

  cmd_t       cmd_r;
  logic       busy_r, busy_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_last_r;

  logic       adv;
  logic [7:0] chr;
  logic       ph_end;
  logic       done;
  logic [1:0] next_phase;
  logic       last;
  logic       load;

  assign adv = busy_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    chr        = CHR_ZERO;
    ph_end     = 1'b0;
    done       = 1'b1;
    next_phase = PH_TRL;
    unique case (phase_r)
      PH_HDR: begin
        unique case (idx_r)
          4'd0:    chr = CHR_STX;
          4'd1:    chr = cmd_r.primary ? CHR_ZERO : CHR_ONE;
          4'd2:    chr = hex_char(cmd_r.len[15:12]);
          4'd3:    chr = hex_char(cmd_r.len[11:8]);
          4'd4:    chr = hex_char(cmd_r.len[7:4]);
          default: chr = hex_char(cmd_r.len[3:0]);
        endcase
        ph_end = (idx_r == 4'd5);
        if (cmd_r.primary) begin
          next_phase = PH_PAD;
          done       = 1'b0;
        end else begin
          done = !cmd_r.trailer;
        end
      end
      PH_PAD: begin
        chr    = CHR_ZERO;
        ph_end = (idx_r == 4'd9);
        done   = !cmd_r.trailer;
      end
      PH_BYTE: begin
        chr    = (idx_r == 4'd0) ? hex_char(cmd_r.data[7:4]) : hex_char(cmd_r.data[3:0]);
        ph_end = (idx_r == 4'd1);
        done   = !cmd_r.trailer;
      end
      default: begin
        chr    = (idx_r < 4'd2) ? CHR_ZERO : CHR_ETX;
        ph_end = (idx_r == 4'd9);
        done   = 1'b1;
      end
    endcase
  end

  assign last  = ph_end && done;
  assign load  = q_valid && (!busy_r || (adv && last));
  assign q_pop = load;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (adv) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else if (ph_end) begin
        phase_nxt = next_phase;
        idx_nxt   = 4'd0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      phase_nxt = (q_cmd.kind == CMD_HEADER) ? PH_HDR : PH_BYTE;
      idx_nxt   = 4'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= q_cmd;
    end
    if (adv) begin
      out_char_r <= chr;
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_HDR;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.last_of_run = out_last_r;

  `FRM_ASSERT(a_idx_in_phase, !busy_r || (phase_r == PH_HDR && idx_r < 4'd6) || (phase_r == PH_PAD && idx_r < 4'd10) || (phase_r == PH_BYTE && idx_r < 4'd2) || (phase_r == PH_TRL && idx_r < 4'd10), "character index outside its phase")
  `FRM_ASSERT(a_pad_only_primary, !(busy_r && phase_r == PH_PAD) || cmd_r.primary, "pad pairs in update frame")

endmodule

// ===== hdl/hex_ascii_config_framer_top.sv =====
// Top level of the hex ASCII configuration framer.
// Depends on frm_pkg, frm_channels, frm_front, frm_queue and frm_back.
//
// The block turns start and data items into the character stream of a
// configuration frame, one character per output transfer. A start item
// produces STX, the command character ('0' primary, '1' update), the length
// 2*(frame_size + dummies) as four upper-case hex digits and, in primary
// mode, five "00" pad pairs: 16 characters in primary mode, 6 in update
// mode. Each data byte of an open frame produces two hex characters, high
// nibble first. After the last counted byte, or right after the header of a
// zero-length frame, the trailer "00" plus eight ETX characters follows (10
// more characters). Data with no open frame is dropped silently; a new start
// abandons an open frame without a trailer. last_of_run marks the final
// character caused by each item. The back end emits one character per clock
// while the output side takes them; that single output register sets the
// rate. The front end accepts one item per clock while the queue is not
// full, into a QUEUE_DEPTH-entry command queue, so items keep arriving
// while earlier characters still drain. After reset the queue is empty
// and in_ch.ready is high.
module hex_ascii_config_framer_top import frm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  frm_in_if.sink     in_ch,
  frm_out_if.source  out_ch
);

  // front to queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  // queue to back
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head_cmd;

  // Classify items and keep the frame byte count.
  frm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  // Decouple item acceptance from character output.
  frm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // Expand each command into characters, one per cycle while the output side takes them.
  frm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_head_valid),
    .q_cmd   (q_head_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
